// ===== rtl/rip_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rip_pkg: shared types and constants for the radix integer parser
// Character codes, field widths, token format and status structs.
// ----------------------------------------------------------------------------
package rip_pkg;

    localparam int OFFSET_LIMIT = 4095;
    localparam int CNT_W        = $clog2(OFFSET_LIMIT + 1);
    localparam int OFF_W        = 12;
    localparam int VAL_W        = 64;
    localparam int CHAR_W       = 8;
    localparam int BASE_W       = 6;
    localparam int DIG_W        = 6;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] LETTER_BIAS = 8'd10;

    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_SIGNED,
        PH_PENDZ,
        PH_DIGITS
    } t_phase;

    // One classified character as it travels through the queue.
    typedef struct packed {
        logic              first;
        logic [BASE_W-1:0] base;
        logic              alnum;
        logic [DIG_W-1:0]  dig;
        logic              blank;
        logic              minus;
        logic              plus;
        logic              zero;
        logic              xch;
    } t_token;

    typedef struct packed {
        logic              valid;
        logic [QCNT_W-1:0] count;
    } t_q_status;

    typedef struct packed {
        logic pop;
        logic emit;
    } t_back_stat;

endpackage : rip_pkg
`default_nettype wire

// ===== rtl/radix_integer_parser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radix_integer_parser_core: streaming strtol-style string to integer parser
// Front classifies characters, a four-entry queue decouples it from the back,
// which runs the parse phases and a 64-bit by 6-bit multiply-accumulate.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while o_stall is low.
// Result path: a terminating character is written to the queue, popped by
//   the back, which registers o_valid; queued tokens ahead of it go first.
// Reset: synchronous active low; parser idle, queue empty, no result pending.
// ----------------------------------------------------------------------------
module radix_integer_parser_core
    import rip_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [CHAR_W-1:0]  i_char_code,
    input  wire logic               i_first,
    input  wire logic [BASE_W-1:0]  i_number_base,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [VAL_W-1:0] o_value,
    output logic [OFF_W-1:0]        o_end_offset
);

    t_token     push_token;
    t_token     pop_token;
    logic       push;
    logic       q_full;
    t_q_status  q_stat;
    t_back_stat b_stat;

    rip_front u_front (
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_char_code   (i_char_code),
        .i_first       (i_first),
        .i_number_base (i_number_base),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_token       (push_token)
    );

    rip_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_token  (push_token),
        .o_full   (q_full),
        .i_pop    (b_stat.pop),
        .o_token  (pop_token),
        .o_status (q_stat)
    );

    rip_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tok_valid  (q_stat.valid),
        .i_token      (pop_token),
        .o_stat       (b_stat),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_value      (o_value),
        .o_end_offset (o_end_offset)
    );

`ifndef SYNTHESIS
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_stat.pop && b_stat.emit) |=> o_valid)
        else $error("emitted result not presented");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_stat.pop |-> (q_stat.count != '0))
        else $error("pop from empty queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !b_stat.pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
        else $error("queue count lost a request");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (q_stat.count == QCNT_W'(QUEUE_DEPTH)))
        else $error("stall without full queue");
`endif

endmodule : radix_integer_parser_core
`default_nettype wire

// ===== rtl/rip_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rip_front: request intake and character classification
// Decodes each character into digit value and class flags for the queue.
// ----------------------------------------------------------------------------
module rip_front
    import rip_pkg::*;
(
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [CHAR_W-1:0] i_char_code,
    input  wire logic              i_first,
    input  wire logic [BASE_W-1:0] i_number_base,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output t_token                 o_token
);

    logic             is_num;
    logic             is_lower;
    logic             is_upper;
    logic [CHAR_W-1:0] dig_full;

    assign is_num   = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
    assign is_lower = (i_char_code >= CH_LA)   && (i_char_code <= CH_LZ);
    assign is_upper = (i_char_code >= CH_UA)   && (i_char_code <= CH_UZ);

    always_comb begin
        if (is_num) begin
            dig_full = i_char_code - CH_ZERO;
        end else if (is_lower) begin
            dig_full = i_char_code - CH_LA + LETTER_BIAS;
        end else begin
            dig_full = i_char_code - CH_UA + LETTER_BIAS;
        end
    end

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_token.first = i_first;
        o_token.base  = i_number_base;
        o_token.alnum = is_num || is_lower || is_upper;
        o_token.dig   = dig_full[DIG_W-1:0];
        o_token.blank = (i_char_code == CH_SPACE) || (i_char_code == CH_TAB);
        o_token.minus = (i_char_code == CH_MINUS);
        o_token.plus  = (i_char_code == CH_PLUS);
        o_token.zero  = (i_char_code == CH_ZERO);
        o_token.xch   = (i_char_code == CH_LX) || (i_char_code == CH_UX);
    end

endmodule : rip_front
`default_nettype wire

// ===== rtl/rip_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rip_queue: token queue between front and back
// Small circular buffer; full stalls the front, empty idles the back.
// ----------------------------------------------------------------------------
module rip_queue
    import rip_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_token i_token,
    output logic        o_full,
    input  wire logic   i_pop,
    output t_token      o_token,
    output t_q_status   o_status
);

    t_token              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_count,  n_count;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_token;
        end
    end

    assign o_full         = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_token        = r_slot[r_rd_ptr];
    assign o_status.valid = (r_count != '0);
    assign o_status.count = r_count;

endmodule : rip_queue
`default_nettype wire

// ===== rtl/rip_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rip_back: parse state machine and accumulator
// One token per cycle unless stalled: runs strtol phases, registers results.
// ----------------------------------------------------------------------------
module rip_back
    import rip_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_tok_valid,
    input  wire t_token             i_token,
    output t_back_stat              o_stat,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [VAL_W-1:0] o_value,
    output logic [OFF_W-1:0]        o_end_offset
);

    t_phase              r_phase, n_phase;
    logic                r_neg,   n_neg;
    logic [BASE_W-1:0]   r_base,  n_base;
    logic [VAL_W-1:0]    r_acc,   n_acc;
    logic [CNT_W-1:0]    r_cnt,   n_cnt;
    logic                r_out_valid, n_out_valid;
    logic [VAL_W-1:0]    r_value;
    logic [OFF_W-1:0]    r_offset;

    t_phase              s_phase;
    logic [VAL_W-1:0]    s_acc;
    logic [CNT_W-1:0]    s_cnt;
    logic                done;
    logic                inc;
    logic                emit;
    logic                pop;

    assign pop = i_tok_valid && (!r_out_valid || !i_stall);

    always_comb begin
        // a first token restarts the parse before the character is looked at
        s_phase = i_token.first ? PH_LEAD : r_phase;
        n_neg   = i_token.first ? 1'b0 : r_neg;
        n_base  = i_token.first ? i_token.base : r_base;
        s_acc   = i_token.first ? '0 : r_acc;
        s_cnt   = i_token.first ? '0 : r_cnt;
        n_phase = s_phase;
        n_acc   = s_acc;
        done    = 1'b0;
        inc     = 1'b0;
        emit    = 1'b0;

        if (s_phase != PH_IDLE) begin
            if (n_phase == PH_LEAD) begin
                if (i_token.blank) begin
                    inc  = 1'b1;
                    done = 1'b1;
                end else if (i_token.minus) begin
                    n_neg   = 1'b1;
                    inc     = 1'b1;
                    n_phase = PH_SIGNED;
                    done    = 1'b1;
                end else if (i_token.plus) begin
                    inc     = 1'b1;
                    n_phase = PH_SIGNED;
                    done    = 1'b1;
                end else begin
                    n_phase = PH_SIGNED;
                end
            end
            if (!done) begin
                if (n_phase == PH_SIGNED) begin
                    if (n_base == BASE_AUTO) begin
                        if (i_token.zero) begin
                            inc     = 1'b1;
                            n_phase = PH_PENDZ;
                            done    = 1'b1;
                        end else begin
                            n_base = BASE_DEC;
                        end
                    end
                    if (!done) begin
                        n_phase = PH_DIGITS;
                    end
                end else if (n_phase == PH_PENDZ) begin
                    if (i_token.xch) begin
                        n_base  = BASE_HEX;
                        inc     = 1'b1;
                        n_phase = PH_DIGITS;
                        done    = 1'b1;
                    end else begin
                        n_base  = BASE_OCT;
                        n_phase = PH_DIGITS;
                    end
                end
            end
            if (!done) begin
                if (i_token.alnum && (i_token.dig < n_base)) begin
                    n_acc = s_acc * VAL_W'(n_base) + VAL_W'(i_token.dig);
                    inc   = 1'b1;
                end else begin
                    emit    = 1'b1;
                    n_phase = PH_IDLE;
                end
            end
        end

        n_cnt = s_cnt;
        if (inc && (s_cnt < CNT_W'(OFFSET_LIMIT))) begin
            n_cnt = s_cnt + 1'b1;
        end

        n_out_valid = r_out_valid;
        if (pop && emit) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_neg       <= 1'b0;
            r_base      <= '0;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (pop) begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_base  <= n_base;
                r_acc   <= n_acc;
                r_cnt   <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && emit) begin
            r_value  <= n_neg ? (VAL_W'(0) - s_acc) : s_acc;
            r_offset <= OFF_W'(s_cnt);
        end
    end

    assign o_stat.pop    = pop;
    assign o_stat.emit   = emit;
    assign o_valid       = r_out_valid;
    assign o_value       = r_value;
    assign o_end_offset  = r_offset;

endmodule : rip_back
`default_nettype wire
